// ----- hw/rtl/partial_merkle_match_extract_macros.svh -----
// Assertion macros used by the checker file of the match extractor.
`ifndef PARTIAL_MERKLE_MATCH_EXTRACT_MACROS_SVH
`define PARTIAL_MERKLE_MATCH_EXTRACT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PMME_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pmme check failed");

// Consequent must hold in the cycle after the antecedent.
`define PMME_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmme check failed");

`endif

// ----- hw/rtl/pmme_pkg.sv -----
// Shared constants and helpers of the partial merkle match extractor.
package pmme_pkg;

   localparam int DEF_MAX_DEPTH  = 24;
   localparam int DEF_INDEX_BITS = 16;

   localparam int TX_W       = 25;
   localparam int CNT_W      = 16;
   localparam int FLAG_W     = 8;
   localparam int CSR_DATA_W = 25;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] REG_TOTAL_TX     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HASH_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_CAPACITY = 2'd2;

   localparam logic [CNT_W-1:0] CAPACITY_RESET = '1;

   // ceil(log2(x)), zero for x of zero or one
   function automatic logic [5:0] ceil_log2_tx(input logic [TX_W-1:0] x);
      logic [5:0] r;
      logic       not_pow2;
      r = '0;
      for (int i = 1; i < TX_W; i++) begin
         if (x[i]) begin
            r = 6'(i);
         end
      end
      not_pow2 = |(x & (x - TX_W'(1)));
      return r + {5'b0, not_pow2};
   endfunction

endpackage

// ----- hw/rtl/pmme_step.sv -----
// One traversal step of the tree walk: consumes one flag bit.
module pmme_step
   import pmme_pkg::*;
#(
   parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
   parameter int INDEX_BITS = DEF_INDEX_BITS,
   localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1),
   localparam int PIDX_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
   input  logic                  flag,
   input  logic [DEPTH_W-1:0]    leaf_depth,
   input  logic [CNT_W-1:0]      hash_count,
   input  logic [CNT_W-1:0]      out_capacity,
   input  logic [DEPTH_W-1:0]    depth_cur,
   input  logic [MAX_DEPTH-1:0]  path_cur,
   input  logic [INDEX_BITS-1:0] pos_cur,
   input  logic [INDEX_BITS-1:0] matches_cur,
   input  logic                  done_cur,
   output logic [DEPTH_W-1:0]    depth_nxt,
   output logic [MAX_DEPTH-1:0]  path_nxt,
   output logic [INDEX_BITS-1:0] pos_nxt,
   output logic [INDEX_BITS-1:0] matches_nxt,
   output logic                  done_nxt,
   output logic                  hit
);

   localparam int CMP_W = (INDEX_BITS > CNT_W) ? INDEX_BITS : CNT_W;

   logic [CMP_W-1:0]     hc_ext;
   logic [MAX_DEPTH-1:0] climb_ok;
   logic                 climb_found;
   logic [PIDX_W-1:0]    climb_lvl;
   logic [MAX_DEPTH-1:0] climb_path;
   logic [INDEX_BITS-1:0] pos_inc;

   assign hc_ext  = CMP_W'(hash_count);
   assign pos_inc = pos_cur + INDEX_BITS'(1);

   // deepest level above the node that was entered by a left child
   always_comb begin
      climb_found = 1'b0;
      climb_lvl   = '0;
      for (int i = 0; i < MAX_DEPTH; i++) begin
         climb_ok[i] = (i < int'(depth_cur)) && !path_cur[i];
         if (climb_ok[i]) begin
            climb_found = 1'b1;
            climb_lvl   = PIDX_W'(i);
         end
      end
      for (int i = 0; i < MAX_DEPTH; i++) begin
         if (i < int'(climb_lvl)) begin
            climb_path[i] = path_cur[i];
         end else begin
            climb_path[i] = (i == int'(climb_lvl));
         end
      end
   end

   always_comb begin
      depth_nxt   = depth_cur;
      path_nxt    = path_cur;
      pos_nxt     = pos_cur;
      matches_nxt = matches_cur;
      done_nxt    = done_cur;
      hit         = 1'b0;
      if (!done_cur) begin
         if (CMP_W'(pos_cur) >= hc_ext) begin
            done_nxt = 1'b1;
         end else if (!flag || (depth_cur >= leaf_depth)) begin
            if (flag && (CMP_W'(matches_cur) < CMP_W'(out_capacity))) begin
               matches_nxt = matches_cur + INDEX_BITS'(1);
               hit         = 1'b1;
            end
            pos_nxt = pos_inc;
            if (climb_found) begin
               path_nxt  = climb_path;
               depth_nxt = DEPTH_W'(climb_lvl) + DEPTH_W'(1);
            end else begin
               done_nxt = 1'b1;
            end
            if (CMP_W'(pos_inc) >= hc_ext) begin
               done_nxt = 1'b1;
            end
         end else begin
            // descend into the left child
            depth_nxt = depth_cur + DEPTH_W'(1);
            path_nxt[depth_cur[PIDX_W-1:0]] = 1'b0;
         end
      end
   end

endmodule

// ----- hw/rtl/partial_merkle_match_extract.sv -----
// Top level of the partial merkle match extractor.
//
//   channel | direction | handshake        | payload
//   req     | in        | valid / ready    | flag_byte, last_byte
//   rsp     | out       | valid / ready    | hash_index, match_count, is_summary, run_end
//   csr     | in        | write enable     | index, wdata
//
// A flag byte passes through the accept state, eight walk steps (one flag bit each
// through the shared step unit) and the flush state; a last byte adds the summary
// state for the summary beat. Matches are held one deep so the final beat of a byte
// can carry run_end; a walk step that finds a match waits while that holding slot
// is full and the output register holds a beat that is not being taken. Reset is
// synchronous and returns the walk state, the CSR registers and the valid flags to
// their reset values.
module partial_merkle_match_extract
   import pmme_pkg::*;
#(
   parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
   parameter int INDEX_BITS = DEF_INDEX_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [FLAG_W-1:0]     req_flag_byte,
   input  logic                  req_last_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [INDEX_BITS-1:0] rsp_hash_index,
   output logic [INDEX_BITS-1:0] rsp_match_count,
   output logic                  rsp_is_summary,
   output logic                  rsp_run_end,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
   localparam int BIT_W   = $clog2(FLAG_W);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH,
      ST_SUMMARY
   } state_type;

   state_type             state_ff;
   logic [TX_W-1:0]       total_tx_ff;
   logic [CNT_W-1:0]      hash_count_ff;
   logic [CNT_W-1:0]      out_capacity_ff;

   logic [FLAG_W-1:0]     flags_ff;
   logic                  last_ff;
   logic [BIT_W-1:0]      bit_cnt_ff;
   logic [DEPTH_W-1:0]    leaf_depth_ff;
   logic [DEPTH_W-1:0]    leaf_depth_in;
   logic [5:0]            leaf_raw;

   logic [DEPTH_W-1:0]    depth_ff,   depth_in;
   logic [MAX_DEPTH-1:0]  path_ff,    path_in;
   logic [INDEX_BITS-1:0] pos_ff,     pos_in;
   logic [INDEX_BITS-1:0] matches_ff, matches_in;
   logic                  done_ff,    done_in;
   logic                  hit;

   logic                  pend_valid_ff;
   logic [INDEX_BITS-1:0] pend_index_ff;
   logic [INDEX_BITS-1:0] pend_count_ff;

   logic                  rsp_valid_ff;
   logic [INDEX_BITS-1:0] rsp_hash_index_ff;
   logic [INDEX_BITS-1:0] rsp_match_count_ff;
   logic                  rsp_is_summary_ff;
   logic                  rsp_run_end_ff;

   logic                  out_free;
   logic                  walk_go;
   logic                  rsp_load;

   pmme_step #(
      .MAX_DEPTH  (MAX_DEPTH),
      .INDEX_BITS (INDEX_BITS)
   ) u_step (
      .flag         (flags_ff[0]),
      .leaf_depth   (leaf_depth_ff),
      .hash_count   (hash_count_ff),
      .out_capacity (out_capacity_ff),
      .depth_cur    (depth_ff),
      .path_cur     (path_ff),
      .pos_cur      (pos_ff),
      .matches_cur  (matches_ff),
      .done_cur     (done_ff),
      .depth_nxt    (depth_in),
      .path_nxt     (path_in),
      .pos_nxt      (pos_in),
      .matches_nxt  (matches_in),
      .done_nxt     (done_in),
      .hit          (hit)
   );

   assign leaf_raw      = ceil_log2_tx(total_tx_ff);
   assign leaf_depth_in = (int'(leaf_raw) > MAX_DEPTH) ? DEPTH_W'(MAX_DEPTH)
                                                       : DEPTH_W'(leaf_raw);

   assign out_free = !rsp_valid_ff || rsp_ready;
   // a match needs room when the holding slot is already taken
   assign walk_go  = !(hit && pend_valid_ff && !out_free);

   // the output register takes a new beat this cycle
   assign rsp_load = ((state_ff == ST_WALK) && walk_go && hit && pend_valid_ff) ||
                     ((state_ff == ST_FLUSH) && pend_valid_ff && out_free) ||
                     ((state_ff == ST_SUMMARY) && out_free);

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hash_index  = rsp_hash_index_ff;
   assign rsp_match_count = rsp_match_count_ff;
   assign rsp_is_summary  = rsp_is_summary_ff;
   assign rsp_run_end     = rsp_run_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         total_tx_ff     <= '0;
         hash_count_ff   <= '0;
         out_capacity_ff <= CAPACITY_RESET;
         depth_ff        <= '0;
         path_ff         <= '0;
         pos_ff          <= '0;
         matches_ff      <= '0;
         done_ff         <= 1'b0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         bit_cnt_ff      <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_TOTAL_TX:     total_tx_ff     <= csr_wdata[TX_W-1:0];
               REG_HASH_COUNT:   hash_count_ff   <= csr_wdata[CNT_W-1:0];
               REG_OUT_CAPACITY: out_capacity_ff <= csr_wdata[CNT_W-1:0];
               default: ;
            endcase
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  flags_ff      <= req_flag_byte;
                  last_ff       <= req_last_byte;
                  leaf_depth_ff <= leaf_depth_in;
                  bit_cnt_ff    <= '0;
                  state_ff      <= ST_WALK;
               end
            end
            ST_WALK: begin
               if (walk_go) begin
                  depth_ff   <= depth_in;
                  path_ff    <= path_in;
                  pos_ff     <= pos_in;
                  matches_ff <= matches_in;
                  done_ff    <= done_in;
                  flags_ff   <= flags_ff >> 1;
                  bit_cnt_ff <= bit_cnt_ff + BIT_W'(1);
                  if (hit) begin
                     if (pend_valid_ff) begin
                        rsp_hash_index_ff  <= pend_index_ff;
                        rsp_match_count_ff <= pend_count_ff;
                        rsp_is_summary_ff  <= 1'b0;
                        rsp_run_end_ff     <= 1'b0;
                     end
                     pend_valid_ff <= 1'b1;
                     pend_index_ff <= pos_ff;
                     pend_count_ff <= matches_in;
                  end
                  if (bit_cnt_ff == BIT_W'(FLAG_W - 1)) begin
                     state_ff <= ST_FLUSH;
                  end
               end
            end
            ST_FLUSH: begin
               if (!pend_valid_ff) begin
                  state_ff <= last_ff ? ST_SUMMARY : ST_IDLE;
               end else if (out_free) begin
                  // last match of the byte ends the run unless a summary follows
                  rsp_hash_index_ff  <= pend_index_ff;
                  rsp_match_count_ff <= pend_count_ff;
                  rsp_is_summary_ff  <= 1'b0;
                  rsp_run_end_ff     <= !last_ff;
                  pend_valid_ff      <= 1'b0;
                  state_ff           <= last_ff ? ST_SUMMARY : ST_IDLE;
               end
            end
            ST_SUMMARY: begin
               if (out_free) begin
                  rsp_hash_index_ff  <= '0;
                  rsp_match_count_ff <= matches_ff;
                  rsp_is_summary_ff  <= 1'b1;
                  rsp_run_end_ff     <= 1'b1;
                  depth_ff           <= '0;
                  path_ff            <= '0;
                  pos_ff             <= '0;
                  matches_ff         <= '0;
                  done_ff            <= 1'b0;
                  state_ff           <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- hw/rtl/pmme_checker.sv -----
// Port-level checks of the match extractor, bound to the top level.
`include "partial_merkle_match_extract_macros.svh"

module pmme_checker
   import pmme_pkg::*;
#(
   parameter int INDEX_BITS = DEF_INDEX_BITS
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [INDEX_BITS-1:0] rsp_hash_index,
   input logic                  rsp_is_summary,
   input logic                  rsp_run_end
);

   // a result beat holds until taken
   `PMME_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // an accepted byte keeps the block busy for its walk
   `PMME_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // the summary always closes the run of its byte
   `PMME_ASSERT_NOW(a_summary_ends_run, clock, reset, rsp_valid && rsp_is_summary, rsp_run_end)

   // the summary carries no hash position
   `PMME_ASSERT_NOW(a_summary_index, clock, reset, rsp_valid && rsp_is_summary,
                    rsp_hash_index == '0)

endmodule

bind partial_merkle_match_extract pmme_checker #(.INDEX_BITS(INDEX_BITS)) u_pmme_checker (.*);

// ----- dv/tb_top.sv -----
// Self-checking bench for the partial merkle match extractor: table-driven and random flag streams.
module tb_top;
   import pmme_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 24;
   localparam int RAND_ITEMS    = 190;
   localparam int SHOW_LIMIT    = 10;

   // index 3 decodes to no register
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [DEF_INDEX_BITS-1:0] idx;
      logic [DEF_INDEX_BITS-1:0] cnt;
      logic                      summ;
      logic                      fin;
   } match_beat_type;

   typedef enum logic {ROW_CSR, ROW_BYTE} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      logic [FLAG_W-1:0]     flags;
      logic                  last;
      bit                    typed;
      int                    n_typed;
      match_beat_type        beat_a;
      match_beat_type        beat_b;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [FLAG_W-1:0]         req_flag_byte = '0;
   logic                      req_last_byte = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [DEF_INDEX_BITS-1:0] rsp_hash_index;
   logic [DEF_INDEX_BITS-1:0] rsp_match_count;
   logic                      rsp_is_summary;
   logic                      rsp_run_end;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   partial_merkle_match_extract dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_flag_byte  (req_flag_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_index (rsp_hash_index),
      .rsp_match_count(rsp_match_count),
      .rsp_is_summary (rsp_is_summary),
      .rsp_run_end    (rsp_run_end),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #6 clock = ~clock;

   // shadow registers and walk state of the predictor
   logic [TX_W-1:0]            cfg_total_tx   = '0;
   logic [CNT_W-1:0]           cfg_hash_count = '0;
   logic [CNT_W-1:0]           cfg_capacity   = CAPACITY_RESET;
   int                         walk_depth     = 0;
   logic [DEF_MAX_DEPTH-1:0]   walk_path      = '0;
   logic [DEF_INDEX_BITS-1:0]  walk_hash      = '0;
   logic [DEF_INDEX_BITS-1:0]  walk_matches   = '0;
   logic                       walk_over      = 1'b0;

   match_beat_type owed_beats[$];
   match_beat_type byte_beats[$];
   stim_row_type   plan[$];

   int  mismatches    = 0;
   int  live_items    = 0;
   int  burst_left    = 0;
   bit  sent_since_cfg = 1'b0;
   int  quiet         = 0;

   function automatic match_beat_type mk_beat(input int idx, input int cnt, input bit summ,
                                              input bit fin);
      match_beat_type b;
      b.idx  = DEF_INDEX_BITS'(idx);
      b.cnt  = DEF_INDEX_BITS'(cnt);
      b.summ = summ;
      b.fin  = fin;
      return b;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] val);
      stim_row_type r;
      r = '{kind: ROW_CSR, reg_idx: idx, reg_val: val, flags: '0, last: 1'b0,
            typed: 1'b0, n_typed: 0, beat_a: '0, beat_b: '0};
      return r;
   endfunction

   function automatic stim_row_type byte_row(input logic [FLAG_W-1:0] f, input logic l);
      stim_row_type r;
      r = '{kind: ROW_BYTE, reg_idx: '0, reg_val: '0, flags: f, last: l,
            typed: 1'b0, n_typed: 0, beat_a: '0, beat_b: '0};
      return r;
   endfunction

   function automatic stim_row_type typed_row(input logic [FLAG_W-1:0] f, input logic l,
                                              input int n, input match_beat_type a,
                                              input match_beat_type b);
      stim_row_type r;
      r = byte_row(f, l);
      r.typed   = 1'b1;
      r.n_typed = n;
      r.beat_a  = a;
      r.beat_b  = b;
      return r;
   endfunction

   // smallest level whose width covers every transaction, capped at the deepest level
   function automatic int tree_leaf_level(input logic [TX_W-1:0] tx);
      int lvl;
      lvl = 0;
      while (lvl < DEF_MAX_DEPTH && (longint'(1) << lvl) < longint'(tx)) lvl++;
      return lvl;
   endfunction

   // climb to the deepest left-entered level and cross to its right sibling
   task automatic step_to_sibling();
      int k;
      k = walk_depth;
      while (k >= 1) begin
         if (!walk_path[k-1]) begin
            for (int j = k; j < DEF_MAX_DEPTH; j++) walk_path[j] = 1'b0;
            walk_path[k-1] = 1'b1;
            walk_depth = k;
            return;
         end
         k--;
      end
      walk_over = 1'b1;
   endtask

   task automatic decode_flag_byte(input logic [FLAG_W-1:0] flags, input logic last);
      int             leaf;
      match_beat_type tail;
      leaf = tree_leaf_level(cfg_total_tx);
      byte_beats.delete();
      for (int b = 0; b < FLAG_W; b++) begin
         if (walk_over) break;
         if (walk_hash >= cfg_hash_count) begin
            walk_over = 1'b1;
            break;
         end
         if (!flags[b] || walk_depth >= leaf) begin
            if (flags[b] && walk_matches < cfg_capacity) begin
               walk_matches++;
               byte_beats.push_back(mk_beat(walk_hash, walk_matches, 1'b0, 1'b0));
            end
            walk_hash++;
            step_to_sibling();
            if (walk_hash >= cfg_hash_count) walk_over = 1'b1;
         end else begin
            walk_depth++;
            walk_path[walk_depth-1] = 1'b0;
         end
      end
      if (last) begin
         byte_beats.push_back(mk_beat(0, walk_matches, 1'b1, 1'b0));
         walk_depth   = 0;
         walk_path    = '0;
         walk_hash    = '0;
         walk_matches = '0;
         walk_over    = 1'b0;
      end
      if (byte_beats.size() != 0) begin
         tail = byte_beats.pop_back();
         tail.fin = 1'b1;
         byte_beats.push_back(tail);
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_TOTAL_TX:     cfg_total_tx   = val[TX_W-1:0];
         REG_HASH_COUNT:   cfg_hash_count = val[CNT_W-1:0];
         REG_OUT_CAPACITY: cfg_capacity   = val[CNT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // drop valid, wait for every owed beat, then let a silent byte finish
   task automatic quiesce();
      req_valid <= 1'b0;
      while (owed_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      sent_since_cfg = 1'b0;
   endtask

   task automatic send_flag_byte(input stim_row_type row);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(20, 60);
            gap = 0;
         end else begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 20);
         end
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_flag_byte <= row.flags;
      req_last_byte <= row.last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // beat accepted at this edge
      sent_since_cfg = 1'b1;
      live_items++;
      decode_flag_byte(row.flags, row.last);
      if (row.typed) begin
         if (row.n_typed >= 1) owed_beats.push_back(row.beat_a);
         if (row.n_typed >= 2) owed_beats.push_back(row.beat_b);
      end else begin
         foreach (byte_beats[i]) owed_beats.push_back(byte_beats[i]);
      end
   endtask

   task automatic run_row(input stim_row_type row);
      if (row.kind == ROW_CSR) begin
         if (sent_since_cfg) quiesce();
         write_csr(row.reg_idx, row.reg_val);
      end else begin
         send_flag_byte(row);
      end
   endtask

   task automatic report_beat(input string what, input match_beat_type want,
                              input match_beat_type got);
      mismatches++;
      if (mismatches <= SHOW_LIMIT) begin
         $write("tb_top: %s: expected idx=%0d count=%0d summary=%0b end=%0b,",
                what, want.idx, want.cnt, want.summ, want.fin);
         $display(" got idx=%0d count=%0d summary=%0b end=%0b",
                  got.idx, got.cnt, got.summ, got.fin);
      end
   endtask

   // result checker
   match_beat_type seen_beat;
   match_beat_type owed_beat;
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         seen_beat.idx  = rsp_hash_index;
         seen_beat.cnt  = rsp_match_count;
         seen_beat.summ = rsp_is_summary;
         seen_beat.fin  = rsp_run_end;
         if (owed_beats.size() == 0) begin
            report_beat("unexpected beat", '0, seen_beat);
         end else begin
            owed_beat = owed_beats.pop_front();
            if (seen_beat.idx !== owed_beat.idx || seen_beat.cnt !== owed_beat.cnt ||
                seen_beat.summ !== owed_beat.summ || seen_beat.fin !== owed_beat.fin)
               report_beat("beat mismatch", owed_beat, seen_beat);
         end
      end
   end

   // receiver stalls follow a rotating pattern, reloaded from a random choice whenever the epoch counter wraps
   logic [15:0] ring  = 16'hFFFF;
   int          epoch = 0;
   always @(posedge clock) begin
      rsp_ready <= ring[0];
      if (epoch == 47) begin
         epoch <= 0;
         case ($urandom_range(0, 3))
            0:       ring <= 16'hFFFF;
            1:       ring <= 16'($urandom) | 16'h0001;
            2:       ring <= 16'($urandom & $urandom) | 16'h0001;
            default: ring <= 16'($urandom | $urandom) | 16'h0001;
         endcase
      end else begin
         epoch <= epoch + 1;
         ring  <= {ring[0], ring[15:1]};
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid === 1'b1 && rsp_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      int                    n_blocks;
      int                    len;
      bit                    noisy;
      logic [FLAG_W-1:0]     f;
      logic                  l;
      logic [TX_W-1:0]       tx;
      logic [CNT_W-1:0]      hc;
      logic [CNT_W-1:0]      cap;

      // no hashes after reset: only the summary
      plan.push_back(typed_row(8'hFF, 1'b1, 1, mk_beat(0, 0, 1, 1), '0));
      // single transaction: the root is a leaf
      plan.push_back(csr_row(REG_TOTAL_TX, 25'd1));
      plan.push_back(csr_row(REG_HASH_COUNT, 25'd1));
      plan.push_back(typed_row(8'h01, 1'b1, 2, mk_beat(0, 1, 0, 0), mk_beat(0, 1, 1, 1)));
      // zero capacity: the leaf uses its hash but reports nothing
      plan.push_back(csr_row(REG_OUT_CAPACITY, 25'd0));
      plan.push_back(typed_row(8'hFF, 1'b1, 1, mk_beat(0, 0, 1, 1), '0));
      plan.push_back(csr_row(REG_OUT_CAPACITY, CSR_DATA_W'(CAPACITY_RESET)));
      plan.push_back(csr_row(REG_TOTAL_TX, 25'd8));
      plan.push_back(csr_row(REG_HASH_COUNT, 25'd15));
      plan.push_back(csr_row(REG_UNUSED, '1));
      // clear root flag finishes the walk; the next byte is ignored but for its summary
      plan.push_back(typed_row(8'h00, 1'b0, 0, '0, '0));
      plan.push_back(typed_row(8'hAA, 1'b1, 1, mk_beat(0, 0, 1, 1), '0));
      plan.push_back(byte_row(8'hFF, 1'b0));
      plan.push_back(byte_row(8'h0F, 1'b0));
      plan.push_back(byte_row(8'h5A, 1'b1));
      // leaf depth saturates; hashes run out mid-byte
      plan.push_back(csr_row(REG_TOTAL_TX, 25'h1FFFFFF));
      plan.push_back(csr_row(REG_HASH_COUNT, 25'd3));
      repeat (3) plan.push_back(byte_row(8'hFF, 1'b0));
      plan.push_back(byte_row(8'h07, 1'b1));
      // full depth, largest hash count, capacity reached part way
      plan.push_back(csr_row(REG_TOTAL_TX, 25'h1000000));
      plan.push_back(csr_row(REG_HASH_COUNT, 25'd65535));
      plan.push_back(csr_row(REG_OUT_CAPACITY, 25'd2));
      repeat (3) plan.push_back(byte_row(8'hFF, 1'b0));
      plan.push_back(byte_row(8'hFF, 1'b1));
      plan.push_back(csr_row(REG_TOTAL_TX, 25'd2));
      plan.push_back(csr_row(REG_OUT_CAPACITY, CSR_DATA_W'(CAPACITY_RESET)));
      plan.push_back(byte_row(8'h07, 1'b1));
      plan.push_back(csr_row(REG_TOTAL_TX, 25'd0));
      plan.push_back(csr_row(REG_HASH_COUNT, 25'd5));
      plan.push_back(byte_row(8'h00, 1'b0));
      plan.push_back(typed_row(8'h01, 1'b1, 1, mk_beat(0, 0, 1, 1), '0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) run_row(plan[i]);

      live_items = 0;
      while (live_items < RAND_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       tx = TX_W'($urandom_range(0, 1));
            7:       tx = TX_W'($urandom_range(65, 4096));
            8:       tx = TX_W'(1) << $urandom_range(0, 24);
            9:       tx = TX_W'($urandom);
            default: tx = TX_W'($urandom_range(2, 64));
         endcase
         case ($urandom_range(0, 7))
            0:       hc = '0;
            1:       hc = CNT_W'($urandom_range(1, 4));
            2:       hc = '1;
            default: hc = CNT_W'($urandom_range(1, 200));
         endcase
         cap = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 6)) : CAPACITY_RESET;
         run_row(csr_row(REG_TOTAL_TX, CSR_DATA_W'(tx)));
         run_row(csr_row(REG_HASH_COUNT, {9'($urandom_range(0, 511)), hc}));
         run_row(csr_row(REG_OUT_CAPACITY, {9'($urandom_range(0, 511)), cap}));
         n_blocks = $urandom_range(1, 3);
         for (int blk = 0; blk < n_blocks; blk++) begin
            noisy = ($urandom_range(0, 4) == 0);
            len   = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
               case ($urandom_range(0, 3))
                  0:       f = FLAG_W'($urandom);
                  1:       f = FLAG_W'($urandom | $urandom);
                  2:       f = FLAG_W'($urandom & $urandom);
                  default: f = FLAG_W'($urandom | $urandom | $urandom);
               endcase
               l = (k == len - 1) || (noisy && $urandom_range(0, 3) == 0);
               run_row(byte_row(f, l));
            end
         end
      end

      quiesce();
      if (owed_beats.size() != 0) mismatches++;
      if (mismatches == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
